/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Each macro takes a label, a clock, a property body and a message;
// ASSERT_PROP also takes an active-low reset that disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

/* rtl/eolnrm_pkg.sv */
package eolnrm_pkg;

	// character codes
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef logic [1:0] eol_kind_t;

	// detected line-ending styles
	localparam eol_kind_t STYLE_UNKNOWN = 2'd0;
	localparam eol_kind_t STYLE_LF      = 2'd1;
	localparam eol_kind_t STYLE_CRLF    = 2'd2;
	localparam eol_kind_t STYLE_CR      = 2'd3;

	// translate enable after reset
	localparam logic TRANSLATE_RESET = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		eol_kind_t  eol_kind;
		logic       style_inconsistent;
	} out_item_t;

endpackage

/* rtl/eolnrm_in_if.sv */
interface eolnrm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

/* rtl/eolnrm_out_if.sv */
interface eolnrm_out_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [1:0] eol_kind;
	logic       style_inconsistent;

	modport source (output valid, output out_valid, output out_byte, output eol_kind,
		output style_inconsistent, input ready);
	modport sink (input valid, input out_valid, input out_byte, input eol_kind,
		input style_inconsistent, output ready);
endinterface

/* rtl/eolnrm_in_reg.sv */
module eolnrm_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	eolnrm_in_if.sink            in_ch,
	input  logic                 advance,
	output logic                 valid_s1,
	output eolnrm_pkg::in_item_t item_s1
);
	import eolnrm_pkg::*;

	logic take;

	// take a request when the stage is empty or moving on this cycle
	assign in_ch.ready = !valid_s1 || advance;
	assign take        = in_ch.valid && in_ch.ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.in_byte       <= in_ch.in_byte;
			item_s1.end_of_stream <= in_ch.end_of_stream;
		end
	end

endmodule

/* rtl/eolnrm_core.sv */
`include "assert_macros.svh"

module eolnrm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  translate_enable,
	input  logic                  fire,
	input  eolnrm_pkg::in_item_t  item,
	output eolnrm_pkg::out_item_t res
);
	import eolnrm_pkg::*;

	logic       prev_cr_q;
	eol_kind_t  style_q;
	logic       mixed_q;

	logic       prev_cr_d;
	eol_kind_t  style_d;
	logic       mixed_d;
	logic       note;
	eol_kind_t  note_style;
	logic       out_valid_c;
	logic [7:0] out_byte_c;
	logic       style_set;

	// decode the byte against the pending CR
	always_comb begin
		prev_cr_d   = prev_cr_q;
		note        = 1'b0;
		note_style  = STYLE_CR;
		out_valid_c = 1'b0;
		out_byte_c  = 8'h00;
		if (item.end_of_stream) begin
			note      = prev_cr_q;
			prev_cr_d = 1'b0;
		end else if (!translate_enable) begin
			out_valid_c = 1'b1;
			out_byte_c  = item.in_byte;
		end else if (item.in_byte == CH_LF) begin
			note        = 1'b1;
			note_style  = prev_cr_q ? STYLE_CRLF : STYLE_LF;
			out_valid_c = !prev_cr_q;
			out_byte_c  = prev_cr_q ? 8'h00 : CH_LF;
			prev_cr_d   = 1'b0;
		end else if (item.in_byte == CH_CR) begin
			note        = prev_cr_q;
			out_valid_c = 1'b1;
			out_byte_c  = CH_LF;
			prev_cr_d   = 1'b1;
		end else begin
			note        = prev_cr_q;
			out_valid_c = 1'b1;
			out_byte_c  = item.in_byte;
			prev_cr_d   = 1'b0;
		end
	end

	// first ending fixes the style, a different one later marks mixed
	always_comb begin
		style_d = style_q;
		mixed_d = mixed_q;
		if (note) begin
			if (style_q == STYLE_UNKNOWN) begin
				style_d = note_style;
			end else if (style_q != note_style) begin
				mixed_d = 1'b1;
			end
		end
	end

	assign res = '{out_valid: out_valid_c, out_byte: out_byte_c, eol_kind: style_d,
		style_inconsistent: mixed_d};

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cr_q <= 1'b0;
			style_q   <= STYLE_UNKNOWN;
			mixed_q   <= 1'b0;
		end else if (fire) begin
			prev_cr_q <= prev_cr_d;
			style_q   <= style_d;
			mixed_q   <= mixed_d;
		end
	end

	assign style_set = (style_q != STYLE_UNKNOWN);

	`ASSERT_PROP(a_style_fixed, clk, arst_n, style_set |=> $stable(style_q), "style changed")
	`ASSERT_PROP(a_mixed_sticky, clk, arst_n, mixed_q |=> mixed_q, "inconsistency flag cleared")
	`ASSERT_PROP(a_mixed_style, clk, arst_n, mixed_q |-> style_set, "mixed flag without style")
	`ASSERT_PROP(a_eos_cr, clk, arst_n, (fire && item.end_of_stream) |=> !prev_cr_q, "CR kept")

endmodule

/* rtl/eolnrm_out_reg.sv */
module eolnrm_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  eolnrm_pkg::out_item_t res,
	output logic                  can_load,
	eolnrm_out_if.source          out_ch
);
	import eolnrm_pkg::*;

	logic      valid_q;
	out_item_t res_q;

	// room when empty or the held result leaves this cycle
	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid              = valid_q;
	assign out_ch.out_valid          = res_q.out_valid;
	assign out_ch.out_byte           = res_q.out_byte;
	assign out_ch.eol_kind           = res_q.eol_kind;
	assign out_ch.style_inconsistent = res_q.style_inconsistent;

endmodule

/* rtl/eol_normalizer_with_style_detect_top.sv */
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the receiver takes results; the single-pass
// step between the two registers and the one-bit pending-CR state allow a new byte
// every cycle when the output is not stalled.
// The input stage takes a request while a finished result waits downstream, if it is itself empty.
// Reset (arst_n low, asynchronous): pipeline empty, no pending CR, style unknown,
// mixed flag clear, translation enabled.
module eol_normalizer_with_style_detect_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	eolnrm_in_if.sink     in_ch,
	eolnrm_out_if.source  out_ch
);
	import eolnrm_pkg::*;

	logic      translate_enable_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      can_load;
	logic      advance;
	out_item_t res;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			translate_enable_q <= TRANSLATE_RESET;
		end else if (cfg_we) begin
			translate_enable_q <= cfg_wdata;
		end
	end

	assign advance = valid_s1 && can_load;

	eolnrm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	eolnrm_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.translate_enable (translate_enable_q),
		.fire             (advance),
		.item             (item_s1),
		.res              (res)
	);

	eolnrm_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

/* tb/eol_normalizer_with_style_detect_top_test.sv */
module eol_normalizer_with_style_detect_top_test;
	import eolnrm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 600;	// result count that starts the long receiver hold
	localparam int HOLD_LEN    = 120;
	localparam int SETTLE      = 4;	// pipeline depth plus margin
	localparam int MAX_REPORT  = 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	eolnrm_in_if  req_ch ();
	eolnrm_out_if res_ch ();

	eol_normalizer_with_style_detect_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (req_ch),
		.out_ch    (res_ch)
	);

	// requests waiting for the driver, predicted results waiting for the monitor
	in_item_t  pending_req[$];
	out_item_t expected_out[$];

	// predictor state
	logic      xlat_en;
	logic      pend_cr;
	eol_kind_t style_seen;
	logic      mixed_seen;

	int n_mismatch  = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// first ending fixes the style, a later different one sets the sticky flag
	function automatic void note_eol(eol_kind_t sty);
		if (style_seen == STYLE_UNKNOWN)
			style_seen = sty;
		else if (style_seen != sty)
			mixed_seen = 1'b1;
	endfunction

	function automatic out_item_t predict_normalized(in_item_t req);
		out_item_t res;
		res.out_valid = 1'b0;
		res.out_byte  = 8'h00;
		if (req.end_of_stream) begin
			// pending CR judged at end of stream, enabled or not
			if (pend_cr)
				note_eol(STYLE_CR);
			pend_cr = 1'b0;
		end else if (!xlat_en) begin
			res.out_valid = 1'b1;
			res.out_byte  = req.in_byte;
		end else if (req.in_byte == CH_LF) begin
			if (pend_cr) begin
				note_eol(STYLE_CRLF);	// LF already produced by the CR
			end else begin
				note_eol(STYLE_LF);
				res.out_valid = 1'b1;
				res.out_byte  = CH_LF;
			end
			pend_cr = 1'b0;
		end else if (req.in_byte == CH_CR) begin
			if (pend_cr)
				note_eol(STYLE_CR);
			res.out_valid = 1'b1;
			res.out_byte  = CH_LF;
			pend_cr = 1'b1;
		end else begin
			if (pend_cr)
				note_eol(STYLE_CR);
			res.out_valid = 1'b1;
			res.out_byte  = req.in_byte;
			pend_cr = 1'b0;
		end
		res.eol_kind           = style_seen;
		res.style_inconsistent = mixed_seen;
		return res;
	endfunction

	// driver: offers queued requests, random gap after each accept
	int unsigned tx_gap;
	int unsigned tx_sent;
	logic        tx_quiet;

	always @(posedge clk or negedge arst_n) begin : driver
		int unsigned gap;
		in_item_t    cur;
		in_item_t    nxt;
		if (!arst_n) begin
			req_ch.valid         <= 1'b0;
			req_ch.in_byte       <= 8'h00;
			req_ch.end_of_stream <= 1'b0;
			tx_gap   <= 0;
			tx_sent  <= 0;
			tx_quiet <= 1'b0;
		end else if (!(req_ch.valid && !req_ch.ready)) begin
			gap = tx_gap;
			if (req_ch.valid) begin
				cur.in_byte       = req_ch.in_byte;
				cur.end_of_stream = req_ch.end_of_stream;
				expected_out.push_back(predict_normalized(cur));
				tx_sent <= tx_sent + 1;
				// every so often switch between gappy and back-to-back traffic
				if (tx_sent % 40 == 0)
					tx_quiet <= ($urandom_range(0, 2) == 0);
				gap = tx_quiet ? 0 : $urandom_range(0, 7);
			end
			if (gap == 0 && pending_req.size() > 0) begin
				nxt = pending_req.pop_front();
				req_ch.valid         <= 1'b1;
				req_ch.in_byte       <= nxt.in_byte;
				req_ch.end_of_stream <= nxt.end_of_stream;
				tx_gap <= 0;
			end else begin
				req_ch.valid <= 1'b0;
				tx_gap <= (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	// monitor: checks each result against the oldest prediction, random stalls
	int unsigned rx_stall;
	int          rx_count;
	logic        rx_quiet;

	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t   got;
		out_item_t   want;
		int unsigned stall;
		if (!arst_n) begin
			res_ch.ready <= 1'b1;
			rx_stall <= 0;
			rx_count = 0;
			rx_quiet <= 1'b0;
		end else if (res_ch.valid && res_ch.ready) begin
			got.out_valid          = res_ch.out_valid;
			got.out_byte           = res_ch.out_byte;
			got.eol_kind           = res_ch.eol_kind;
			got.style_inconsistent = res_ch.style_inconsistent;
			if (expected_out.size() == 0) begin
				if (n_mismatch < MAX_REPORT)
					$display("unexpected result: valid=%0b byte=%02h style=%0d mixed=%0b",
						got.out_valid, got.out_byte, got.eol_kind, got.style_inconsistent);
				n_mismatch++;
			end else begin
				want = expected_out.pop_front();
				if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
					got.eol_kind !== want.eol_kind ||
					got.style_inconsistent !== want.style_inconsistent) begin
					if (n_mismatch < MAX_REPORT)
						$display("result %0d: expected %0b/%02h/%0d/%0b, got %0b/%02h/%0d/%0b",
							rx_count, want.out_valid, want.out_byte, want.eol_kind,
							want.style_inconsistent, got.out_valid, got.out_byte,
							got.eol_kind, got.style_inconsistent);
					n_mismatch++;
				end
			end
			rx_count = rx_count + 1;
			if (rx_count % 56 == 0)
				rx_quiet <= ($urandom_range(0, 2) == 0);
			stall = rx_quiet ? 0 : $urandom_range(0, 7);
			// one long hold so the pipeline fills and backs up the input
			if (rx_count == HOLD_AT)
				stall = HOLD_LEN;
			if (stall == 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				rx_stall <= stall - 1;
			end
		end else if (!res_ch.ready) begin
			if (rx_stall == 0)
				res_ch.ready <= 1'b1;
			else
				rx_stall <= rx_stall - 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("eol_normalizer_with_style_detect_top_test: done, errors");
			$finish;
		end
	end

	task automatic push_req(input logic [7:0] b, input logic eos);
		in_item_t r;
		r.in_byte       = b;
		r.end_of_stream = eos;
		pending_req.push_back(r);
	endtask

	task automatic push_ending(input eol_kind_t sty);
		case (sty)
			STYLE_LF: begin
				push_req(CH_LF, 1'b0);
			end
			STYLE_CRLF: begin
				push_req(CH_CR, 1'b0);
				push_req(CH_LF, 1'b0);
			end
			default: begin
				push_req(CH_CR, 1'b0);
			end
		endcase
	endtask

	// wait until every request is out and every result checked
	task automatic drain();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || req_ch.valid || expected_out.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_xlat(input logic en);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		xlat_en = en;
	endtask

	// text lines with endings mostly of one style, plus raw bytes and stream ends
	task automatic gen_text(input int n);
		int        added;
		int        k;
		int        len;
		eol_kind_t main_sty;
		eol_kind_t sty;
		added    = 0;
		main_sty = eol_kind_t'($urandom_range(1, 3));
		while (added < n) begin
			k = $urandom_range(0, 19);
			if (k < 14) begin
				len = $urandom_range(0, 10);
				repeat (len) push_req(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
				sty = ($urandom_range(0, 7) == 0) ? eol_kind_t'($urandom_range(1, 3)) : main_sty;
				push_ending(sty);
				added += len + ((sty == STYLE_CRLF) ? 2 : 1);
			end else if (k < 18) begin
				push_req(8'($urandom_range(0, 255)), 1'b0);
				added++;
			end else if (k == 18) begin
				push_req(8'($urandom_range(0, 255)), 1'b1);
				added++;
			end else begin
				push_req(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF, 1'b0);
				added++;
			end
		end
	endtask

	initial begin : stimulus
		logic xlat_plan[6];
		int   size_plan[6];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		xlat_en    = TRANSLATE_RESET;
		pend_cr    = 1'b0;
		style_seen = STYLE_UNKNOWN;
		mixed_seen = 1'b0;
		xlat_plan  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		size_plan  = '{300, 200, 300, 300, 180, 300};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset-default translation, every ending kind, byte extremes
		push_req(8'hFF, 1'b1);	// end of stream with nothing pending
		push_req(8'h00, 1'b0);
		push_req(8'hFF, 1'b0);
		push_req("a", 1'b0);
		push_ending(eol_kind_t'($urandom_range(1, 3)));	// first ending sets the style
		push_req(CH_LF, 1'b0);
		push_req(CH_CR, 1'b0);
		push_req(CH_LF, 1'b0);	// dropped LF
		push_req(CH_CR, 1'b0);
		push_req(CH_CR, 1'b0);	// CR followed by CR
		push_req("d", 1'b0);
		push_req(CH_CR, 1'b0);
		push_req(CH_CR, 1'b1);	// CR pending at end of stream
		push_req(CH_LF, 1'b0);	// LF after the cleared mark is emitted
		push_req(CH_CR, 1'b0);	// leave a CR pending into the disabled phase
		drain();

		// disabled: bytes pass through, pending CR untouched
		write_xlat(1'b0);
		push_req(CH_CR, 1'b0);
		push_req(CH_LF, 1'b0);
		push_req(8'hFF, 1'b0);
		push_req(8'h00, 1'b0);
		drain();

		// re-enabled: the held CR pairs with this LF
		write_xlat(1'b1);
		push_req(CH_LF, 1'b0);
		push_req(CH_CR, 1'b0);
		drain();

		// end of stream while disabled still judges the pending CR
		write_xlat(1'b0);
		push_req(8'h5A, 1'b1);
		drain();

		// random phases over both settings
		for (int ph = 0; ph < 6; ph++) begin
			write_xlat(xlat_plan[ph]);
			gen_text(size_plan[ph]);
			drain();
		end

		if (n_mismatch == 0)
			$display("eol_normalizer_with_style_detect_top_test: done, clean");
		else
			$display("eol_normalizer_with_style_detect_top_test: done, errors");
		$finish;
	end

endmodule
